/* rtl/core/crc8dfr_pkg.sv */
// Package for the CRC-8 checked frame deframer: sizes, register indexes,
// reset values, shared types and the reflected CRC-8 byte update.
// No dependencies.
package crc8dfr_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int FILL_W      = 4;
  localparam int CFG_IDX_W   = 2;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_BYTES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER = 2'd0,
    REG_FOOTER = 2'd1,
    REG_POLY   = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] HEADER_RESET = 8'hAA;
  localparam logic [7:0] FOOTER_RESET = 8'h55;
  localparam logic [7:0] POLY_RESET   = 8'h8C;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] footer_byte;
    logic [7:0] crc_poly;
  } cfg_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  frame_command;
    logic [31:0] frame_value;
  } check_t;

  // One byte of a reflected (LSB-first) CRC-8.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] crc;
    logic [7:0] d;
    logic       lsb;
    crc = crc_in;
    d   = data;
    for (int b = 0; b < 8; b++) begin
      lsb = crc[0] ^ d[0];
      crc = {1'b0, crc[7:1]};
      if (lsb) begin
        crc = crc ^ poly;
      end
      d = {1'b0, d[7:1]};
    end
    return crc;
  endfunction

endpackage

/* rtl/core/crc8dfr_cfg.sv */
// Configuration registers of the deframer: header, footer and polynomial.
// Depends on crc8dfr_pkg.
module crc8dfr_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [crc8dfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                        cfg_data,
  output crc8dfr_pkg::cfg_t                 cfg
);
  import crc8dfr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte <= HEADER_RESET;
      cfg.footer_byte <= FOOTER_RESET;
      cfg.crc_poly    <= POLY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEADER: cfg.header_byte <= cfg_data;
        REG_FOOTER: cfg.footer_byte <= cfg_data;
        REG_POLY:   cfg.crc_poly    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/crc8dfr_check.sv */
// Frame check on the registered byte window: header, footer and CRC-8
// compare, plus extraction of command and little-endian value.
// Depends on crc8dfr_pkg.
module crc8dfr_check (
  input  logic [7:0]                       win [crc8dfr_pkg::FRAME_BYTES],
  input  logic [crc8dfr_pkg::FILL_W-1:0]   fill,
  input  logic                             fresh,
  input  crc8dfr_pkg::cfg_t                cfg,
  output crc8dfr_pkg::check_t              chk
);
  import crc8dfr_pkg::*;

  logic [7:0] crc [6];

  // Byte 1 (command) through byte 5 run through the CRC; byte 6 is the check.
  assign crc[0] = 8'h00;
  for (genvar i = 0; i < 5; i++) begin : g_crc
    assign crc[i+1] = crc8_byte(crc[i], win[i+1], cfg.crc_poly);
  end

  always_comb begin
    chk.hit = fresh &&
              (fill == FILL_FULL) &&
              (win[0] == cfg.header_byte) &&
              (win[FRAME_BYTES-1] == cfg.footer_byte) &&
              (crc[5] == win[6]);
    chk.frame_command = win[1];
    chk.frame_value   = {win[5], win[4], win[3], win[2]};
  end

endmodule

/* rtl/core/crc8dfr_window.sv */
// Input stage: sliding window of the last eight bytes and the count of
// bytes since reset or since the last delivered frame.
// Depends on crc8dfr_pkg.
module crc8dfr_window (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_fire,
  input  logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  input  logic                            frame_taken,
  output logic [7:0]                      win [crc8dfr_pkg::FRAME_BYTES],
  output logic [crc8dfr_pkg::FILL_W-1:0]  fill,
  output logic                            fresh
);
  import crc8dfr_pkg::*;

  logic [FILL_W-1:0] fill_next;

  always_comb begin
    fill_next = fill;
    if (frame_taken) begin
      // frame consumed: count restarts, including a byte arriving now
      fill_next = in_fire ? FILL_W'(1) : '0;
    end else if (in_fire && fill != FILL_FULL) begin
      fill_next = fill + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      fresh <= 1'b0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        win[i] <= 8'h00;
      end
    end else begin
      fill <= fill_next;
      // check each window once, right after its newest byte lands;
      // hold the mark while a found frame waits for the result register
      fresh <= in_fire || (fresh && !in_ready);
      if (in_fire) begin
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
          win[i] <= win[i+1];
        end
        win[FRAME_BYTES-1] <= rx_byte;
      end
    end
  end

endmodule

/* rtl/core/crc8dfr_out.sv */
// Result register for accepted frames on the master-side stream.
// Depends on crc8dfr_pkg.
module crc8dfr_out (
  input  logic                 clk,
  input  logic                 rst,
  input  crc8dfr_pkg::check_t  chk,
  output logic                 frame_taken,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata
);
  import crc8dfr_pkg::*;

  logic load;

  assign load        = chk.hit && (!m_axis_tvalid || m_axis_tready);
  assign frame_taken = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {chk.frame_value, chk.frame_command};
    end
  end

endmodule

/* rtl/core/crc8_checked_frame_deframer_top.sv */
// CRC-8 checked frame deframer: sliding 8-byte window with header, footer
// and reflected CRC-8 check. Depends on crc8dfr_pkg and the crc8dfr_* modules.
//
// Usage:
//   s_axis carries received bytes, one byte per request. m_axis carries one
//   request per accepted frame: command byte and 32-bit little-endian value.
//   cfg_we/cfg_index/cfg_data write header (0), footer (1) and polynomial (2)
//   while the block is idle; other indexes are ignored.
// Path: a byte that completes a valid frame is taken into the window
//   register; the frame is checked from the window register and loaded
//   into the result register on m_axis once that register is free.
// Throughput: one byte per cycle while s_axis_tready is high. The window
//   register's check (five unrolled CRC-8 bytes) sits in front of the
//   result register.
// Reset: window cleared to zeros, fill count zero, registers to 0xAA, 0x55,
//   0x8C, no result pending.
// Stall: while a checked frame waits in the window and the result register
//   is still held by the receiver, s_axis_tready drops; otherwise bytes keep
//   flowing while a result waits.
module crc8_checked_frame_deframer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [39:0]                       m_axis_tdata,  // [7:0] frame_command,
                                                           // [39:8] frame_value
  input  logic                              cfg_we,
  input  logic [crc8dfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                        cfg_data
);
  import crc8dfr_pkg::*;

  cfg_t              cfg;
  check_t            chk;
  logic [7:0]        win [FRAME_BYTES];
  logic [FILL_W-1:0] fill;
  logic              fresh;
  logic              frame_taken;
  logic              in_fire;

  // hold input while a found frame cannot move into the result register
  assign s_axis_tready = !chk.hit || frame_taken;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  crc8dfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  crc8dfr_window u_window (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .in_ready    (s_axis_tready),
    .rx_byte     (s_axis_tdata),
    .frame_taken (frame_taken),
    .win         (win),
    .fill        (fill),
    .fresh       (fresh)
  );

  crc8dfr_check u_check (
    .win   (win),
    .fill  (fill),
    .fresh (fresh),
    .cfg   (cfg),
    .chk   (chk)
  );

  crc8dfr_out u_out (
    .clk           (clk),
    .rst           (rst),
    .chk           (chk),
    .frame_taken   (frame_taken),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
